/* src/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants for the rolling checksum chunker
// Sizes of the history window, chunk limit, config register indexes and
// the word passed from the checksum front end to the cut-decision back end.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int MAX_WINDOW = 4096;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = PTR_W + 1;
  localparam int DIV_W      = 25;
  localparam int LEN_W      = 25;
  localparam int SUM_W      = 32;
  localparam int CFG_W      = 25;
  localparam logic [LEN_W-1:0] MAX_CHUNK = LEN_W'(24'hFFFFFF) + LEN_W'(1);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CHUNK_DIVISOR = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } rcc_reg_t;

  // word handed from front to back: checksum after the byte, end flag
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } rcc_item_t;

endpackage

/* src/rcc_front.sv */
// ----------------------------------------------------------------------------
// rcc_front: byte intake and rolling checksum update
// Holds the window history memory, the pointer and the fill count. Each byte
// goes through a history read, then checksum update and queue push.
// ----------------------------------------------------------------------------
module rcc_front import rcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  input  logic [WIN_W-1:0] win,
  input  logic             q_full,
  output logic             q_push,
  output rcc_item_t        q_data
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CALC = 2'b10
  } fstate_t;

  fstate_t          state;
  logic [7:0]       hist [MAX_WINDOW];
  logic [7:0]       rd_byte;
  logic [7:0]       cur_byte;
  logic             cur_end;
  logic [SUM_W-1:0] rolling_sum;
  logic [PTR_W-1:0] ptr;
  logic [WIN_W-1:0] fill;
  logic             start;
  logic             accept;
  logic [WIN_W-1:0] fill_eff;
  logic [15:0]      s1, s2, s1_next, s2_next;
  logic [21:0]      prod;
  logic [PTR_W-1:0] ridx;

  assign in_stall = (state != F_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;
  assign ridx     = ptr - win[PTR_W-1:0];

  // history memory: read at accept, write during update
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_byte  <= hist[ridx];
      cur_byte <= data_byte;
      cur_end  <= stream_end;
    end
    if (state == F_CALC) begin
      hist[ptr] <= cur_byte;
    end
  end

  // checksum arithmetic
  always_comb begin
    s1       = rolling_sum[15:0];
    s2       = rolling_sum[31:16];
    fill_eff = start ? win : fill;
    prod     = win * ({1'b0, rd_byte} + 9'd1);
    if (fill_eff != '0) begin
      s1_next = s1 + {8'd0, cur_byte} + 16'd1;
    end else begin
      s1_next = s1 - {8'd0, rd_byte} + {8'd0, cur_byte};
    end
    if (fill_eff != '0) begin
      s2_next = s2 + s1_next;
    end else begin
      s2_next = s2 - prod[15:0] + s1_next;
    end
  end

  assign q_push = (state == F_CALC);
  assign q_data = '{sum: {s2_next, s1_next}, last: cur_end};

  // control and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      rolling_sum <= '0;
      ptr         <= '0;
      fill        <= '0;
      start       <= 1'b1;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) state <= F_CALC;
        end
        F_CALC: begin
          state <= F_IDLE;
          if (cur_end) begin
            rolling_sum <= '0;
            ptr         <= '0;
            start       <= 1'b1;
          end else begin
            rolling_sum <= {s2_next, s1_next};
            ptr         <= ptr + PTR_W'(1);
            start       <= 1'b0;
            fill        <= (fill_eff != '0) ? fill_eff - WIN_W'(1) : fill_eff;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* src/rcc_queue.sv */
// ----------------------------------------------------------------------------
// rcc_queue: two-entry queue between front and back
// Lets the front start the next byte while the back still decides a cut.
// ----------------------------------------------------------------------------
module rcc_queue import rcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rcc_item_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output rcc_item_t head
);

  rcc_item_t  mem [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_idx];

  always_ff @(posedge clk) begin
    if (push) mem[wr_idx] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_idx <= ~wr_idx;
      if (pop)  rd_idx <= ~rd_idx;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/rcc_back.sv */
// ----------------------------------------------------------------------------
// rcc_back: cut decision and result register
// Bit-serial remainder of the checksum by the divisor, chunk byte count,
// and the output register that holds a finished chunk word.
// ----------------------------------------------------------------------------
module rcc_back import rcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIV_W-1:0] divisor,
  input  logic             q_valid,
  input  rcc_item_t        q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] chunk_length,
  output logic [SUM_W-1:0] cut_checksum,
  output logic             forced_cut,
  output logic             final_chunk
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  bstate_t          state;
  logic [LEN_W-1:0] bytes_in_chunk;
  logic [LEN_W-1:0] cur_len;
  logic [SUM_W-1:0] cur_sum;
  logic             cur_end;
  logic [SUM_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [4:0]       step;
  logic [DIV_W:0]   trial;
  logic             forced;
  logic             cut;
  logic             out_free;
  logic             load_out;

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign trial    = {rem, quo[SUM_W-1]};
  assign forced   = (cur_len >= MAX_CHUNK);
  assign cut      = forced || (rem == '0) || cur_end;
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == B_DONE) && cut && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      bytes_in_chunk <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur_sum <= q_head.sum;
            cur_end <= q_head.last;
            cur_len <= bytes_in_chunk + LEN_W'(1);
            quo     <= q_head.sum;
            rem     <= '0;
            step    <= '0;
            state   <= B_DIV;
          end
        end
        // one quotient bit per cycle, restoring
        B_DIV: begin
          if (trial >= {1'b0, divisor}) begin
            rem <= DIV_W'(trial - {1'b0, divisor});
          end else begin
            rem <= trial[DIV_W-1:0];
          end
          quo  <= {quo[SUM_W-2:0], 1'b0};
          step <= step + 5'd1;
          if (step == 5'd31) state <= B_DONE;
        end
        B_DONE: begin
          if (!cut) begin
            bytes_in_chunk <= cur_len;
            state          <= B_IDLE;
          end else if (out_free) begin
            bytes_in_chunk <= '0;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // result register: load a finished chunk word, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid    <= 1'b1;
      chunk_length <= cur_len;
      cut_checksum <= cur_sum;
      forced_cut   <= forced;
      final_chunk  <= cur_end;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* src/rolling_checksum_chunker_unit.sv */
// ----------------------------------------------------------------------------
// rolling_checksum_chunker_unit: content-defined chunker, rolling checksum
// Splits a byte stream into chunks where the rolling checksum divides
// evenly, at the maximum chunk length, or at the end of the stream.
//
//   channel | direction | handshake           | word
//   input   | in        | in_valid/in_stall   | data_byte, stream_end
//   output  | out       | out_valid/out_stall | chunk_length, cut_checksum,
//           |           |                     | forced_cut, final_chunk
//   config  | in        | cfg_write           | cfg_index, cfg_data
//
// Front handles one byte at a time (history read, then checksum update).
// Back handles one byte at a time: pop, 32 remainder steps, decision; the
// bit-serial remainder unit sets the sustained byte rate.
// Synchronous reset; no clearing pass, history is valid once written.
// A stalled result holds in the output register; the front keeps working
// until the two-entry queue fills.
// ----------------------------------------------------------------------------
module rolling_checksum_chunker_unit import rcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] chunk_length,
  output logic [SUM_W-1:0] cut_checksum,
  output logic             forced_cut,
  output logic             final_chunk
);

  logic [DIV_W-1:0] chunk_divisor;
  logic [WIN_W-1:0] window_length;
  logic [DIV_W-1:0] div_eff;
  logic [WIN_W-1:0] win_eff;
  logic             q_full, q_push, q_pop, q_valid;
  rcc_item_t        q_in, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_divisor <= DIV_W'(65536);
      window_length <= WIN_W'(MAX_WINDOW);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHUNK_DIVISOR: chunk_divisor <= cfg_data[DIV_W-1:0];
        REG_WINDOW_LENGTH: window_length <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero divisor acts as one; window clamped to 1..MAX_WINDOW
  assign div_eff = (chunk_divisor == '0) ? DIV_W'(1) : chunk_divisor;
  always_comb begin
    win_eff = window_length;
    if (window_length == '0) win_eff = WIN_W'(1);
    if (window_length > WIN_W'(MAX_WINDOW)) win_eff = WIN_W'(MAX_WINDOW);
  end

  rcc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .stream_end,
    .win(win_eff), .q_full, .q_push, .q_data(q_in)
  );

  rcc_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  rcc_back u_back (
    .clk, .rst, .divisor(div_eff), .q_valid, .q_head, .q_pop,
    .out_valid, .out_stall, .chunk_length, .cut_checksum, .forced_cut,
    .final_chunk
  );

`ifndef SYNTHESIS
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chunk_length != '0)
    else $error("chunk word with zero length");

  a_forced_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && forced_cut) |-> chunk_length == MAX_CHUNK)
    else $error("forced cut at wrong length");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_full || q_pop))
    else $error("queue overflow");
`endif

endmodule

/* tb/sv/rolling_checksum_chunker_checker.sv */
// ----------------------------------------------------------------------------
// rolling_checksum_chunker_checker: chunk predictor and result comparator
// Watches the byte and chunk channels and the config port. It keeps its own
// rolling checksum, window history and chunk count, queues the chunk each
// accepted byte ends, and compares every chunk word against the oldest one.
// ----------------------------------------------------------------------------
module rolling_checksum_chunker_checker import rcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [LEN_W-1:0] chunk_length,
  input  logic [SUM_W-1:0] cut_checksum,
  input  logic             forced_cut,
  input  logic             final_chunk,
  output int               fail_count,
  output int               chunks_pending
);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] sum;
    logic             forced;
    logic             last;
  } chunk_t;

  chunk_t chunk_q[$];

  logic [DIV_W-1:0] divisor;
  logic [WIN_W-1:0] win_len;
  logic [SUM_W-1:0] csum;
  logic [7:0]       hist [MAX_WINDOW];
  logic [PTR_W-1:0] ptr;
  logic [WIN_W-1:0] fill_left;
  logic [LEN_W-1:0] chunk_bytes;
  logic             fresh_stream;

  // effective window length: 0 acts as 1, capped at MAX_WINDOW
  function automatic int eff_window();
    int w;
    w = int'(win_len);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return w;
  endfunction

  // advance the checksum by one byte and queue a chunk if it ends here
  task automatic chunk_step(input logic [7:0] b, input logic last);
    int w;
    logic [15:0] s1, s2, r;
    logic [31:0] bytes;
    logic [DIV_W-1:0] div;
    logic forced;
    chunk_t c;
    w = eff_window();
    s1 = csum[15:0];
    s2 = csum[31:16];
    div = (divisor == 0) ? DIV_W'(1) : divisor;
    if (fresh_stream) begin
      fill_left = WIN_W'(w);
      fresh_stream = 1'b0;
    end
    if (fill_left != 0) begin
      fill_left--;
      s1 = s1 + 16'(b) + 16'd1;
      s2 = s2 + s1;
    end else begin
      r = 16'(hist[PTR_W'(int'(ptr) + MAX_WINDOW - w)]);
      s1 = s1 - r + 16'(b);
      s2 = s2 - 16'(w * (int'(r) + 1)) + s1;
    end
    csum = {s2, s1};
    hist[ptr] = b;
    ptr++;
    bytes = 32'(chunk_bytes) + 1;
    chunk_bytes = LEN_W'(bytes);
    forced = bytes >= 32'(MAX_CHUNK);
    if (forced || (csum % 32'(div)) == 0 || last) begin
      c.len = chunk_bytes;
      c.sum = csum;
      c.forced = forced;
      c.last = last;
      chunk_q.push_back(c);
      chunk_bytes = '0;
      if (last) begin
        csum = '0;
        ptr = '0;
        fresh_stream = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    chunk_t e;
    if (rst) begin
      divisor = DIV_W'(65536);
      win_len = WIN_W'(4096);
      csum = '0;
      ptr = '0;
      fill_left = WIN_W'(4096);
      chunk_bytes = '0;
      fresh_stream = 1'b1;
      chunk_q.delete();
      fail_count = 0;
    end else begin
      // compare an accepted chunk word
      if (out_valid && !out_stall) begin
        if (chunk_q.size() == 0) begin
          $error("chunk word with none expected");
          fail_count++;
        end else begin
          e = chunk_q.pop_front();
          if (chunk_length !== e.len) begin
            $error("chunk_length exp %0d got %0d", e.len, chunk_length);
            fail_count++;
          end
          if (cut_checksum !== e.sum) begin
            $error("cut_checksum exp %h got %h", e.sum, cut_checksum);
            fail_count++;
          end
          if (forced_cut !== e.forced) begin
            $error("forced_cut exp %0d got %0d", e.forced, forced_cut);
            fail_count++;
          end
          if (final_chunk !== e.last) begin
            $error("final_chunk exp %0d got %0d", e.last, final_chunk);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) chunk_step(data_byte, stream_end);
      if (cfg_write) begin
        if (cfg_index == REG_CHUNK_DIVISOR) divisor = DIV_W'(cfg_data);
        else win_len = WIN_W'(cfg_data);
      end
    end
    chunks_pending = chunk_q.size();
  end

endmodule

/* tb/sv/rolling_checksum_chunker_unit_test.sv */
// ----------------------------------------------------------------------------
// rolling_checksum_chunker_unit_test: stimulus and verdict for the chunker
// Streams bytes under several divisor and window settings, with random
// gaps and output stalls, while the checker predicts and compares chunks.
// ----------------------------------------------------------------------------
module rolling_checksum_chunker_unit_test;
  import rcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [0:0]       cfg_index = REG_CHUNK_DIVISOR;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = '0;
  logic             stream_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [LEN_W-1:0] chunk_length;
  logic [SUM_W-1:0] cut_checksum;
  logic             forced_cut;
  logic             final_chunk;
  int               fail_count;
  int               chunks_pending;
  int               cycles = 0;
  bit               calm = 1'b0;
  int               stream_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rolling_checksum_chunker_unit dut (.*);
  rolling_checksum_chunker_checker chk (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rolling_checksum_chunker_unit_test NOT OK");
      $finish;
    end
  end

  // output stalls in short bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // present one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    stream_end <= last;
    // stall only moves at the rising edge, so it is settled here
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  // drop valid, wait out every pending chunk and the back-end latency
  task automatic drain();
    in_valid <= 1'b0;
    while (chunks_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input rcc_reg_t idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // random stream bytes, ending streams every so often
  task automatic random_bytes(input int n);
    logic last;
    repeat (n) begin
      if (stream_left == 0) stream_left = $urandom_range(1, 60);
      stream_left--;
      last = (stream_left == 0);
      send_byte(8'($urandom), last);
    end
  endtask

  initial begin
    int divs[6];
    int wins[6];
    divs = '{1, 0, 7, 16777216, 33554431, 256};
    wins = '{1, 0, 5, 8191, 4096, 16};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: field extremes under reset settings, then every byte cuts
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    drain();
    write_reg(REG_CHUNK_DIVISOR, 0);
    write_reg(REG_WINDOW_LENGTH, 3);
    for (int i = 0; i < 10; i++) send_byte(8'(i * 29), i == 9);
    drain();
    // random phases over several settings; window only changes when idle
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CHUNK_DIVISOR, divs[p]);
      write_reg(REG_WINDOW_LENGTH, wins[p]);
      random_bytes(200);
      // close the stream so a longer window never reads stale history
      send_byte(8'($urandom), 1'b1);
      stream_left = 0;
      drain();
    end
    write_reg(REG_CHUNK_DIVISOR, 3);
    write_reg(REG_WINDOW_LENGTH, 2);
    calm = 1'b1;
    random_bytes(300);
    send_byte(8'h5A, 1'b1);
    drain();
    if (fail_count == 0) begin
      $display("rolling_checksum_chunker_unit_test OK");
    end else begin
      $display("rolling_checksum_chunker_unit_test NOT OK");
    end
    $finish;
  end

endmodule
